>>> hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Tick count to calendar fields package
// Shared constants and types for the tick to calendar conversion core.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int TicksW = 63;
  localparam logic [23:0] TicksPerSec = 24'd10000000;
  localparam logic [13:0] TicksPerMs = 14'd10000;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0] SecsPerMin = 6'd60;
  localparam logic [14:0] BaseYear = 15'd1601;
  localparam logic [17:0] DaysPer400y = 18'd146097;

  // Each shift is 63 plus the bit length of its divisor, so the rounded-up
  // reciprocal gives the exact quotient for every 63-bit dividend.
  localparam int ShiftSec = 87;
  localparam int ShiftMs = 77;
  localparam int ShiftDay = 80;
  localparam int ShiftHour = 75;
  localparam int ShiftMin = 69;
  localparam int ShiftWday = 66;
  localparam int ShiftCyc = 81;

  localparam logic [63:0] RecipSec =
    64'((128'd1 << ShiftSec) / 128'(TicksPerSec) + 128'd1);
  localparam logic [63:0] RecipMs =
    64'((128'd1 << ShiftMs) / 128'(TicksPerMs) + 128'd1);
  localparam logic [63:0] RecipDay =
    64'((128'd1 << ShiftDay) / 128'(SecsPerDay) + 128'd1);
  localparam logic [63:0] RecipHour =
    64'((128'd1 << ShiftHour) / 128'(SecsPerHour) + 128'd1);
  localparam logic [63:0] RecipMin =
    64'((128'd1 << ShiftMin) / 128'(SecsPerMin) + 128'd1);
  localparam logic [63:0] RecipWday =
    64'((128'd1 << ShiftWday) / 128'd7 + 128'd1);
  localparam logic [63:0] RecipCyc =
    64'((128'd1 << ShiftCyc) / 128'(DaysPer400y) + 128'd1);

  typedef enum logic [2:0] {
    DIV_SEC, DIV_MS, DIV_DAY, DIV_HOUR, DIV_MIN, DIV_WDAY, DIV_CYC
  } div_sel_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
    logic [2:0] weekday;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    begin
      case (m) inside
        4'd1: r = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
        default: r = 5'd31;
      endcase
      return r;
    end
  endfunction

  function automatic logic [23:0] div_divisor(input div_sel_t sel);
    logic [23:0] d;
    begin
      unique case (sel)
        DIV_SEC: d = TicksPerSec;
        DIV_MS: d = 24'(TicksPerMs);
        DIV_DAY: d = 24'(SecsPerDay);
        DIV_HOUR: d = 24'(SecsPerHour);
        DIV_MIN: d = 24'(SecsPerMin);
        DIV_WDAY: d = 24'd7;
        DIV_CYC: d = 24'(DaysPer400y);
        default: d = '0;
      endcase
      return d;
    end
  endfunction

  function automatic logic [63:0] div_recip(input div_sel_t sel);
    logic [63:0] m;
    begin
      unique case (sel)
        DIV_SEC: m = RecipSec;
        DIV_MS: m = RecipMs;
        DIV_DAY: m = RecipDay;
        DIV_HOUR: m = RecipHour;
        DIV_MIN: m = RecipMin;
        DIV_WDAY: m = RecipWday;
        DIV_CYC: m = RecipCyc;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

>>> hw/rtl/tcc_divider.sv
// ----------------------------------------------------------------------------
// Tick count to calendar constant divider
// Shared divider by a selected constant: the quotient comes from a reciprocal
// multiplication and the remainder from a multiply back and subtract, both on
// one 32 by 32 multiplier.
// ----------------------------------------------------------------------------
module tcc_divider
  import tcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  div_sel_t          sel,
  input  logic [TicksW-1:0] dividend,
  output logic              done,
  output logic [TicksW-1:0] quotient,
  output logic [23:0]       remainder
);

  logic busy;
  logic [2:0] step;
  div_sel_t sel_q;
  logic [TicksW-1:0] num;
  logic [63:0] recip;
  logic [23:0] divisor;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [127:0] acc;
  logic [63:0] low;
  logic [TicksW-1:0] q_shifted;

  assign recip = div_recip(sel_q);
  assign divisor = div_divisor(sel_q);
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    case (step)
      3'd0: begin
        mul_a = num[31:0];
        mul_b = recip[31:0];
      end
      3'd1: begin
        mul_a = num[31:0];
        mul_b = recip[63:32];
      end
      3'd2: begin
        mul_a = {1'b0, num[TicksW-1:32]};
        mul_b = recip[31:0];
      end
      3'd3: begin
        mul_a = {1'b0, num[TicksW-1:32]};
        mul_b = recip[63:32];
      end
      3'd5: begin
        mul_a = quotient[31:0];
        mul_b = {8'd0, divisor};
      end
      3'd6: begin
        mul_a = {1'b0, quotient[TicksW-1:32]};
        mul_b = {8'd0, divisor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (sel_q)
      DIV_SEC: q_shifted = TicksW'(acc >> ShiftSec);
      DIV_MS: q_shifted = TicksW'(acc >> ShiftMs);
      DIV_DAY: q_shifted = TicksW'(acc >> ShiftDay);
      DIV_HOUR: q_shifted = TicksW'(acc >> ShiftHour);
      DIV_MIN: q_shifted = TicksW'(acc >> ShiftMin);
      DIV_WDAY: q_shifted = TicksW'(acc >> ShiftWday);
      DIV_CYC: q_shifted = TicksW'(acc >> ShiftCyc);
      default: q_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        num <= dividend;
        sel_q <= sel;
      end else if (busy) begin
        step <= step + 3'd1;
        case (step) inside
          3'd0: acc <= {64'd0, prod};
          3'd1, 3'd2: acc <= acc + {32'd0, prod, 32'd0};
          3'd3: acc <= acc + {prod, 64'd0};
          3'd4: quotient <= q_shifted;
          3'd5: low <= prod;
          3'd6: low <= low + {prod[31:0], 32'd0};
          default: begin
            remainder <= 24'(num - TicksW'(low));
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/tick_count_to_calendar_fields_core.sv
// ----------------------------------------------------------------------------
// Tick count to calendar fields core
// Converts 100 ns ticks since 1601-01-01 into Gregorian calendar fields.
// ----------------------------------------------------------------------------
// Seven passes through a shared constant divider split the tick count into
// milliseconds, seconds, days, hours, minutes, the weekday and the 400-year
// cycle; a year walk of up to 399 steps and a month walk of up to 11 steps
// follow. Input ready is low from acceptance until the result transfer
// completes.
module tick_count_to_calendar_fields_core
  import tcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        epoch_weekday,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TicksW-1:0] ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [14:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second,
  output logic [9:0]        millisecond,
  output logic [2:0]        weekday
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEC, S_MS, S_DAY, S_HOUR, S_MIN, S_WDAY, S_CYC, S_YEAR, S_MONTH, S_OUT
  } state_t;

  state_t state;
  logic [2:0] epoch;
  logic div_start, div_done;
  div_sel_t div_sel;
  logic [TicksW-1:0] div_a, quo;
  logic [23:0] rem;
  logic [TicksW-1:0] days;
  logic [17:0] dleft;
  logic [8:0] yoff;
  logic leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  cal_t res;

  tcc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .sel(div_sel), .dividend(div_a),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  // The cycle starts in a year one past a multiple of 400, so the offsets 99,
  // 199 and 299 are the common century years and 399 is the leap one.
  assign leap = (yoff[1:0] == 2'd3) && (yoff != 9'd99) && (yoff != 9'd199) &&
                (yoff != 9'd299);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(res.month - 4'd1, leap);

  assign year = res.year;
  assign month = res.month;
  assign day = res.day;
  assign hour = res.hour;
  assign minute = res.minute;
  assign second = res.second;
  assign millisecond = res.millisecond;
  assign weekday = res.weekday;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      epoch <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        epoch <= epoch_weekday;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            div_a <= ticks;
            div_sel <= DIV_SEC;
            div_start <= 1'b1;
            state <= S_SEC;
          end
        end
        S_SEC: begin
          if (div_done) begin
            days <= quo;
            div_a <= TicksW'(rem);
            div_sel <= DIV_MS;
            div_start <= 1'b1;
            state <= S_MS;
          end
        end
        S_MS: begin
          if (div_done) begin
            res.millisecond <= quo[9:0];
            div_a <= days;
            div_sel <= DIV_DAY;
            div_start <= 1'b1;
            state <= S_DAY;
          end
        end
        S_DAY: begin
          if (div_done) begin
            days <= quo;
            div_a <= TicksW'(rem[16:0]);
            div_sel <= DIV_HOUR;
            div_start <= 1'b1;
            state <= S_HOUR;
          end
        end
        S_HOUR: begin
          if (div_done) begin
            res.hour <= quo[4:0];
            div_a <= TicksW'(rem[11:0]);
            div_sel <= DIV_MIN;
            div_start <= 1'b1;
            state <= S_MIN;
          end
        end
        S_MIN: begin
          if (div_done) begin
            res.minute <= quo[5:0];
            res.second <= rem[5:0];
            div_a <= days + TicksW'(epoch);
            div_sel <= DIV_WDAY;
            div_start <= 1'b1;
            state <= S_WDAY;
          end
        end
        S_WDAY: begin
          if (div_done) begin
            res.weekday <= rem[2:0];
            div_a <= days;
            div_sel <= DIV_CYC;
            div_start <= 1'b1;
            state <= S_CYC;
          end
        end
        S_CYC: begin
          if (div_done) begin
            res.year <= BaseYear + {quo[6:0], 8'd0} + {quo[7:0], 7'd0} + {quo[10:0], 4'd0};
            yoff <= '0;
            dleft <= rem[17:0];
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (dleft < 18'(ylen)) begin
            res.month <= 4'd1;
            state <= S_MONTH;
          end else begin
            dleft <= dleft - 18'(ylen);
            res.year <= res.year + 15'd1;
            yoff <= yoff + 9'd1;
          end
        end
        S_MONTH: begin
          if (res.month == 4'd12 || dleft < 18'(mlen)) begin
            res.day <= dleft[4:0] + 5'd1;
            state <= S_OUT;
          end else begin
            dleft <= dleft - 18'(mlen);
            res.month <= res.month + 4'd1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
